### rtl/wns_pkg.sv
// Shared types, codes and constants of the weighted neighbor selector.
`timescale 1ns / 1ps
`default_nettype none

package wns_pkg;

    // Fixed field widths of the stream payloads
    localparam int OP_W       = 2;
    localparam int IN_ID_W    = 20;
    localparam int RATE_W     = 32;
    localparam int FRAC_W     = 32;
    localparam int ST_W       = 3;
    localparam int OUT_ID_W   = 20;
    localparam int PROB_W     = 32;
    localparam int ESC_W      = 48;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 136;

    // Shared arithmetic unit sizing
    localparam int DIVB_W     = 49;
    localparam int STEP_W     = 6;
    localparam int MUL_STEPS  = 32;
    localparam int PROB_STEPS = 33;
    localparam int ESC_STEPS  = 49;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_PICK  = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK           = 3'd0,
        ST_ZERO_RATE    = 3'd1,
        ST_FULL         = 3'd2,
        ST_NOT_NEIGHBOR = 3'd3,
        ST_EMPTY        = 3'd4
    } t_status;

    typedef enum logic {
        AM_MUL = 1'b0,
        AM_DIV = 1'b1
    } t_amode;

    typedef struct packed {
        logic              start;
        t_amode            mode;
        logic [STEP_W-1:0] steps;
    } t_arith_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FOUND,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_MUL_WAIT,
        S_WALK_RD,
        S_WALK_CHK,
        S_PROB_WAIT,
        S_ESC,
        S_ESC_WAIT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/wns_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module wns_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/wns_arith.sv
// Shared bit-serial unit: shift-add multiply and restoring divide on one adder.
`timescale 1ns / 1ps
`default_nettype none

module wns_arith import wns_pkg::*; #(
    parameter int SUMW = 36
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_arith_cmd        i_cmd,
    input  wire logic [SUMW-1:0]   i_opa,    // multiplicand or divisor
    input  wire logic [SUMW-1:0]   i_init,   // starting remainder for divide
    input  wire logic [DIVB_W-1:0] i_bits,   // dividend bits MSB first, or multiplier
    output logic                   o_done,
    output logic      [DIVB_W-1:0] o_result
);

    t_amode            r_mode,  n_mode;
    logic [STEP_W-1:0] r_cnt,   n_cnt;
    logic              r_done,  n_done;
    logic [SUMW-1:0]   r_acc,   n_acc;
    logic [DIVB_W-1:0] r_low,   n_low;

    logic [SUMW:0]     w_a;
    logic [SUMW:0]     w_b;
    logic              w_sub;
    logic [SUMW+1:0]   w_t;
    logic              w_qbit;

    // Shared add/subtract
    always_comb begin
        w_sub = (r_mode == AM_DIV);
        w_a   = w_sub ? {r_acc, r_low[DIVB_W-1]} : {1'b0, r_acc};
        w_b   = (w_sub || r_low[0]) ? {1'b0, i_opa} : '0;
        w_t   = {1'b0, w_a} + ({1'b0, w_b} ^ {(SUMW+2){w_sub}}) + (SUMW+2)'(w_sub);
        w_qbit = ~w_t[SUMW+1];
    end

    // Load on start, then one step per cycle
    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_low  = r_low;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_mode = i_cmd.mode;
            n_cnt  = i_cmd.steps;
            n_acc  = i_init;
            n_low  = i_bits;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - STEP_W'(1);
            n_done = (r_cnt == STEP_W'(1));
            if (r_mode == AM_DIV) begin
                n_acc = w_qbit ? w_t[SUMW-1:0] : w_a[SUMW-1:0];
                n_low = {r_low[DIVB_W-2:0], w_qbit};
            end else begin
                n_acc = w_t[SUMW:1];
                n_low = {r_low[DIVB_W-1:MUL_STEPS], w_t[0], r_low[MUL_STEPS-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_mode <= n_mode;
        r_acc  <= n_acc;
        r_low  <= n_low;
    end

    assign o_done   = r_done;
    assign o_result = (r_mode == AM_DIV) ? r_low : DIVB_W'(r_acc);

endmodule

`default_nettype wire

### rtl/weighted_neighbor_selector.sv
// Top level: sorted neighbor table, sequencer and result register.
//
//   channel  direction  tdata fields (low bit up)                      tuser
//   s_axis   in         neighbor_id, rate, random_fraction             op
//   m_axis   out        chosen_id, rate_out, probability, escape_time  status
//
// set_rate: a table scan for the id, entries moved up one place on insert, then the
// 49-step escape divide.
// pick: 32-step multiply, a walk over the entries, then the escape divide.
// query: table scan, 33-step probability divide, then the escape divide.
// Reset clears the entry count and the rate sum; the table needs no clearing.
// A finished result waits in the output register while the next item runs.
`timescale 1ns / 1ps
`default_nettype none

module weighted_neighbor_selector import wns_pkg::*; #(
    parameter int MAX_NEIGHBORS = 16,
    parameter int ID_BITS       = 20
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // neighbor_id[19:0], rate[51:20], random_fraction[83:52], zero fill
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [OP_W-1:0]      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // chosen_id[19:0], rate_out[51:20], probability[83:52], escape_time[131:84], zero fill
    output logic      [M_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic      [ST_W-1:0]      m_axis_tuser
);

    localparam int SUMW  = RATE_W + $clog2(MAX_NEIGHBORS);
    localparam int CNTW  = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDXW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int ENT_W = ID_BITS + RATE_W;

    t_state               r_state, n_state;
    t_op                  r_op,    n_op;
    logic [ID_BITS-1:0]   r_key,   n_key;
    logic [RATE_W-1:0]    r_rate,  n_rate;
    logic [FRAC_W-1:0]    r_frac,  n_frac;
    logic [CNTW-1:0]      r_count, n_count;
    logic [SUMW-1:0]      r_sum,   n_sum;
    logic [CNTW-1:0]      r_idx,   n_idx;
    logic                 r_found, n_found;
    logic [CNTW-1:0]      r_pos,   n_pos;
    logic [RATE_W-1:0]    r_old,   n_old;
    logic [SUMW-1:0]      r_thr,   n_thr;
    logic [SUMW-1:0]      r_cum,   n_cum;
    t_status              r_status, n_status;
    logic [ID_BITS-1:0]   r_chosen, n_chosen;
    logic [RATE_W-1:0]    r_rate_out, n_rate_out;
    logic [PROB_W-1:0]    r_prob,  n_prob;
    logic [ESC_W-1:0]     r_esc,   n_esc;
    logic                 r_o_valid;
    logic [M_TDATA_W-1:0] r_o_tdata;
    logic [ST_W-1:0]      r_o_tuser;

    logic                 w_accept;
    logic                 w_load;
    logic [ID_BITS+IN_ID_W-1:0]  w_id_ext;
    logic [ID_BITS+OUT_ID_W-1:0] w_chosen_ext;
    logic [CNTW-1:0]      w_idx_m1;
    logic [ID_BITS-1:0]   w_e_id;
    logic [RATE_W-1:0]    w_e_rate;
    logic [SUMW-1:0]      w_cum_next;
    logic                 w_full;

    logic                 w_we;
    logic [IDXW-1:0]      w_waddr;
    logic [ENT_W-1:0]     w_wdata;
    logic                 w_re;
    logic [IDXW-1:0]      w_raddr;
    logic [ENT_W-1:0]     w_rdata;

    t_arith_cmd           w_cmd;
    logic [SUMW-1:0]      w_ar_init;
    logic [DIVB_W-1:0]    w_ar_bits;
    logic                 w_ar_done;
    logic [DIVB_W-1:0]    w_ar_res;

    // Table storage: one entry holds {id, rate}
    wns_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_NEIGHBORS),
        .AW    (IDXW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Shared multiply/divide unit
    wns_arith #(
        .SUMW (SUMW)
    ) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_opa    (r_sum),
        .i_init   (w_ar_init),
        .i_bits   (w_ar_bits),
        .o_done   (w_ar_done),
        .o_result (w_ar_res)
    );

    // Common decodes
    always_comb begin
        w_accept     = s_axis_tvalid && s_axis_tready;
        w_load       = (r_state == S_DONE) && (!r_o_valid || m_axis_tready);
        w_id_ext     = {{ID_BITS{1'b0}}, s_axis_tdata[IN_ID_W-1:0]};
        w_chosen_ext = {{OUT_ID_W{1'b0}}, r_chosen};
        w_idx_m1     = r_idx - CNTW'(1);
        w_e_id       = w_rdata[ENT_W-1:RATE_W];
        w_e_rate     = w_rdata[RATE_W-1:0];
        w_cum_next   = r_cum + SUMW'(w_e_rate);
        w_full       = (r_count == CNTW'(MAX_NEIGHBORS));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_op)
                    OP_SET:   n_state = (r_rate == '0) ? S_ESC : S_SCAN_RD;
                    OP_PICK:  n_state = (r_count == '0) ? S_ESC : S_MUL_WAIT;
                    OP_QUERY: n_state = (r_count == '0) ? S_ESC : S_SCAN_RD;
                    default:  n_state = S_ESC;
                endcase
            end
            S_SCAN_RD: begin
                n_state = (r_idx == r_count) ? S_FOUND : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                n_state = (w_e_id >= r_key) ? S_FOUND : S_SCAN_RD;
            end
            S_FOUND: begin
                if (r_op == OP_SET) begin
                    n_state = (r_found || w_full) ? S_ESC : S_SHIFT_RD;
                end else begin
                    n_state = r_found ? S_PROB_WAIT : S_ESC;
                end
            end
            S_SHIFT_RD: begin
                n_state = (r_idx == r_pos) ? S_INSERT : S_SHIFT_WR;
            end
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_INSERT:   n_state = S_ESC;
            S_MUL_WAIT: begin
                if (w_ar_done) n_state = S_WALK_RD;
            end
            S_WALK_RD:  n_state = S_WALK_CHK;
            S_WALK_CHK: begin
                n_state = (w_cum_next > r_thr) ? S_ESC : S_WALK_RD;
            end
            S_PROB_WAIT: begin
                if (w_ar_done) n_state = S_ESC;
            end
            S_ESC: begin
                n_state = (r_sum == '0) ? S_DONE : S_ESC_WAIT;
            end
            S_ESC_WAIT: begin
                if (w_ar_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath controls and next values
    always_comb begin
        n_op       = r_op;
        n_key      = r_key;
        n_rate     = r_rate;
        n_frac     = r_frac;
        n_count    = r_count;
        n_sum      = r_sum;
        n_idx      = r_idx;
        n_found    = r_found;
        n_pos      = r_pos;
        n_old      = r_old;
        n_thr      = r_thr;
        n_cum      = r_cum;
        n_status   = r_status;
        n_chosen   = r_chosen;
        n_rate_out = r_rate_out;
        n_prob     = r_prob;
        n_esc      = r_esc;
        w_we       = 1'b0;
        w_waddr    = r_pos[IDXW-1:0];
        w_wdata    = {r_key, r_rate};
        w_re       = 1'b0;
        w_raddr    = r_idx[IDXW-1:0];
        w_cmd      = '{start: 1'b0, mode: AM_DIV, steps: STEP_W'(ESC_STEPS)};
        w_ar_init  = '0;
        w_ar_bits  = {1'b1, {(DIVB_W-1){1'b0}}};
        s_axis_tready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                // Capture the input transfer
                if (w_accept) begin
                    n_op   = t_op'(s_axis_tuser);
                    n_key  = w_id_ext[ID_BITS-1:0];
                    n_rate = s_axis_tdata[IN_ID_W+RATE_W-1:IN_ID_W];
                    n_frac = s_axis_tdata[IN_ID_W+RATE_W+FRAC_W-1:IN_ID_W+RATE_W];
                end
            end
            S_DECODE: begin
                n_status   = ST_OK;
                n_chosen   = '0;
                n_rate_out = '0;
                n_prob     = '0;
                n_idx      = '0;
                case (r_op)
                    OP_SET: begin
                        if (r_rate == '0) n_status = ST_ZERO_RATE;
                    end
                    OP_PICK: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            // Threshold = frac * sum >> 32
                            w_cmd     = '{start: 1'b1, mode: AM_MUL,
                                          steps: STEP_W'(MUL_STEPS)};
                            w_ar_bits = DIVB_W'(r_frac);
                        end
                    end
                    OP_QUERY: begin
                        if (r_count == '0) n_status = ST_EMPTY;
                    end
                    default: ;
                endcase
            end
            S_SCAN_RD: begin
                // Ran off the end: id is absent, insert at the tail
                if (r_idx == r_count) begin
                    n_found = 1'b0;
                    n_pos   = r_idx;
                end else begin
                    w_re = 1'b1;
                end
            end
            S_SCAN_CHK: begin
                // Sorted table: first id not below the key decides
                n_old = w_e_rate;
                if (w_e_id >= r_key) begin
                    n_found = (w_e_id == r_key);
                    n_pos   = r_idx;
                end else begin
                    n_idx = r_idx + CNTW'(1);
                end
            end
            S_FOUND: begin
                if (r_op == OP_SET) begin
                    if (r_found) begin
                        // Overwrite the rate and adjust the sum
                        w_we  = 1'b1;
                        n_sum = r_sum - SUMW'(r_old) + SUMW'(r_rate);
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_idx = r_count;
                    end
                end else if (r_found) begin
                    // Probability = rate * 2^32 / sum
                    n_rate_out = r_old;
                    w_cmd      = '{start: 1'b1, mode: AM_DIV,
                                   steps: STEP_W'(PROB_STEPS)};
                    w_ar_init  = SUMW'({1'b0, r_old[RATE_W-1:1]});
                    w_ar_bits  = {r_old[0], {(DIVB_W-1){1'b0}}};
                end else begin
                    n_status = ST_NOT_NEIGHBOR;
                end
            end
            S_SHIFT_RD: begin
                // Read the entry below the hole
                if (r_idx != r_pos) begin
                    w_re    = 1'b1;
                    w_raddr = w_idx_m1[IDXW-1:0];
                end
            end
            S_SHIFT_WR: begin
                // Move it up one place
                w_we    = 1'b1;
                w_waddr = r_idx[IDXW-1:0];
                w_wdata = w_rdata;
                n_idx   = w_idx_m1;
            end
            S_INSERT: begin
                w_we    = 1'b1;
                n_count = r_count + CNTW'(1);
                n_sum   = r_sum + SUMW'(r_rate);
            end
            S_MUL_WAIT: begin
                if (w_ar_done) begin
                    n_thr = w_ar_res[SUMW-1:0];
                    n_cum = '0;
                    n_idx = '0;
                end
            end
            S_WALK_RD: begin
                w_re = 1'b1;
            end
            S_WALK_CHK: begin
                // Accumulate until the running sum passes the threshold
                if (w_cum_next > r_thr) begin
                    n_chosen = w_e_id;
                end else begin
                    n_cum = w_cum_next;
                    n_idx = r_idx + CNTW'(1);
                end
            end
            S_PROB_WAIT: begin
                if (w_ar_done) begin
                    n_prob = w_ar_res[PROB_W] ? '1 : w_ar_res[PROB_W-1:0];
                end
            end
            S_ESC: begin
                // Escape time = 2^48 / sum
                if (r_sum == '0) begin
                    n_esc = '0;
                end else begin
                    w_cmd = '{start: 1'b1, mode: AM_DIV, steps: STEP_W'(ESC_STEPS)};
                end
            end
            S_ESC_WAIT: begin
                if (w_ar_done) begin
                    n_esc = w_ar_res[ESC_W] ? '1 : w_ar_res[ESC_W-1:0];
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // Control and table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_sum     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_sum     <= n_sum;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_rate     <= n_rate;
        r_frac     <= n_frac;
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_old      <= n_old;
        r_thr      <= n_thr;
        r_cum      <= n_cum;
        r_status   <= n_status;
        r_chosen   <= n_chosen;
        r_rate_out <= n_rate_out;
        r_prob     <= n_prob;
        r_esc      <= n_esc;
    end

    // Output register: hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_tdata <= M_TDATA_W'({r_esc, r_prob, r_rate_out,
                                     w_chosen_ext[OUT_ID_W-1:0]});
            r_o_tuser <= r_status;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_tdata;
    assign m_axis_tuser  = r_o_tuser;

endmodule

`default_nettype wire
